@@ rtl/sidp_pkg.sv @@
// ----------------------------------------------------------------------------
// sidp_pkg
// shared widths and register map for the softened inverse distance unit
// ----------------------------------------------------------------------------
package sidp_pkg;
    localparam int unsigned QW = 32;           // q16.16 word
    localparam int unsigned SW = 33;           // sum width
    localparam int unsigned DW = 49;           // dividend width (2^48)
    localparam int unsigned RW = 25;           // root width (max 2^24)
    localparam logic [31:0] QMAX = 32'hFFFF_FFFF;
    localparam logic [0:0]  ADDR_SOFTENING_SQ = 1'b0;

    // one item moving through the pipeline
    typedef struct packed {
        logic          zero;   // self pair
        logic [SW-1:0] s;      // softened sum
    } t_ctl;
endpackage

@@ rtl/softened_inverse_distance_powers_unit.sv @@
// ----------------------------------------------------------------------------
// softened_inverse_distance_powers_unit
// plummer-softened inverse distance powers in unsigned q16.16
// ----------------------------------------------------------------------------
// Takes one squared distance per item, adds the softening register and
// returns 1/sqrt(s), 1/s and 1/s^1.5, each truncated, with 1/s and 1/s^1.5
// saturated to 0xFFFFFFFF; a zero distance gives all zeros. One item enters
// per cycle while the pipe advances. The pipe is 77 register stages deep:
// one for the sum, 49 restoring-divider stages (2^48/s, one quotient bit
// each), 25 square root stages (one root bit each), one multiply stage and
// the output register. 2^32/s is taken as the quotient shifted right by 16.
// The whole pipe advances when the output register is empty or being taken.
// ----------------------------------------------------------------------------
module softened_inverse_distance_powers_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_dist_sq,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_inv_dist,
    output logic [31:0] o_inv_dist_sq,
    output logic [31:0] o_inv_dist_cube
);
    localparam int unsigned DW = sidp_pkg::DW;
    localparam int unsigned RW = sidp_pkg::RW;

    // config register
    logic [31:0] r_soft;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sidp_pkg::ADDR_SOFTENING_SQ) ? r_soft : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft <= '0;
        end else if (psel && penable && pwrite
                     && paddr[2] == sidp_pkg::ADDR_SOFTENING_SQ) begin
            r_soft <= pwdata;
        end
    end

    // pipe advances whenever the output slot is free or drains
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // stage 0: sum
    logic           r_v0;
    sidp_pkg::t_ctl r_c0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
        if (en) begin
            r_c0.zero <= (i_dist_sq == '0);
            r_c0.s    <= {1'b0, i_dist_sq} + {1'b0, r_soft};
        end
    end

    logic               dv_v;
    sidp_pkg::t_ctl     dv_c;
    logic [DW-1:0]      dv_q;
    sidp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_v0), .i_ctl(r_c0),
        .o_valid(dv_v), .o_ctl(dv_c), .o_quo(dv_q)
    );

    logic               sq_v;
    sidp_pkg::t_ctl     sq_c;
    logic [DW-1:0]      sq_d;
    logic [RW-1:0]      sq_r;
    sidp_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(dv_v), .i_ctl(dv_c), .i_val(dv_q),
        .o_valid(sq_v), .o_ctl(sq_c), .o_val(sq_d), .o_root(sq_r)
    );

    // q2 = 2^32/s = floor(q48 / 2^16), 33 bits
    logic [32:0] q2;
    assign q2 = sq_d[48:16];

    // multiply stage: q1 * q2 (25 x 33)
    logic        r_vm;
    logic        r_zm;
    logic [57:0] r_prod;
    logic [32:0] r_q2;
    logic [RW-1:0] r_q1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (en) begin
            r_vm <= sq_v;
        end
        if (en) begin
            r_zm   <= sq_c.zero;
            r_prod <= {33'b0, sq_r} * {25'b0, q2};
            r_q2   <= q2;
            r_q1   <= sq_r;
        end
    end

    // output register with saturation
    logic [41:0] q3;
    assign q3 = r_prod[57:16];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_vm;
        end
        if (en) begin
            if (r_zm) begin
                o_inv_dist      <= '0;
                o_inv_dist_sq   <= '0;
                o_inv_dist_cube <= '0;
            end else begin
                o_inv_dist      <= 32'(r_q1);
                o_inv_dist_sq   <= r_q2[32] ? sidp_pkg::QMAX : r_q2[31:0];
                o_inv_dist_cube <= (q3[41:32] != '0) ? sidp_pkg::QMAX : q3[31:0];
            end
        end
    end

    // a held result stays valid and its cube output stays put while the sink stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_inv_dist_cube))
        else $error("result changed under stall");
    // inverse distance never exceeds 2^24
    a_q1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_inv_dist <= 32'h0100_0000)
        else $error("inverse distance out of range");
    // a result appears only after something entered the pipe
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vm))
        else $error("result without item");
endmodule

@@ rtl/sidp_div.sv @@
// ----------------------------------------------------------------------------
// sidp_div
// pipelined restoring divider, 2^48 / s, one quotient bit per stage
// ----------------------------------------------------------------------------
module sidp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  sidp_pkg::t_ctl               i_ctl,
    output logic                         o_valid,
    output sidp_pkg::t_ctl               o_ctl,
    output logic [sidp_pkg::DW-1:0]      o_quo
);
    localparam int unsigned N = sidp_pkg::DW;
    localparam int unsigned SW = sidp_pkg::SW;

    logic [N:1]           r_v;
    sidp_pkg::t_ctl       r_c   [1:N];
    logic [SW:0]          r_rem [1:N];
    logic [N-1:0]         r_q   [1:N];

    for (genvar k = 0; k < N; k++) begin : g_st
        logic           v_in;
        sidp_pkg::t_ctl c_in;
        logic [SW:0]    rem_in;
        logic [N-1:0]   q_in;
        logic [SW+1:0]  t;
        logic           b;
        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign c_in   = i_ctl;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[k];
            assign c_in   = r_c[k];
            assign rem_in = r_rem[k];
            assign q_in   = r_q[k];
        end
        // dividend is a single one at bit 48: shifted in at stage 0
        always_comb begin
            t = {rem_in, (k == 0) ? 1'b1 : 1'b0};
            if (c_in.s == '0) b = 1'b0;
            else              b = (t >= {2'b0, c_in.s});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
            if (i_en) begin
                r_c[k+1]   <= c_in;
                r_rem[k+1] <= b ? (SW+1)'(t - {2'b0, c_in.s}) : t[SW:0];
                r_q[k+1]   <= {q_in[N-2:0], b};
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_ctl   = r_c[N];
    assign o_quo   = r_q[N];
endmodule

@@ rtl/sidp_sqrt.sv @@
// ----------------------------------------------------------------------------
// sidp_sqrt
// pipelined digit-by-digit square root of the 49-bit quotient
// ----------------------------------------------------------------------------
module sidp_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  sidp_pkg::t_ctl               i_ctl,
    input  logic [sidp_pkg::DW-1:0]      i_val,
    output logic                         o_valid,
    output sidp_pkg::t_ctl               o_ctl,
    output logic [sidp_pkg::DW-1:0]      o_val,
    output logic [sidp_pkg::RW-1:0]      o_root
);
    localparam int unsigned DW = sidp_pkg::DW;
    localparam int unsigned RW = sidp_pkg::RW;
    localparam int unsigned M  = 2 * RW;   // padded radicand width

    logic [RW:1]        r_v;
    sidp_pkg::t_ctl     r_c   [1:RW];
    logic [DW-1:0]      r_d   [1:RW];
    logic [M-1:0]       r_x   [1:RW];
    logic [RW+1:0]      r_rem [1:RW];
    logic [RW-1:0]      r_r   [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic           v_in;
        sidp_pkg::t_ctl c_in;
        logic [DW-1:0]  d_in;
        logic [M-1:0]   x_in;
        logic [RW+1:0]  rem_in;
        logic [RW-1:0]  r_in;
        logic [RW+1:0]  t;
        logic [RW+1:0]  trial;
        logic           b;
        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign c_in   = i_ctl;
            assign d_in   = i_val;
            assign x_in   = M'(i_val);
            assign rem_in = '0;
            assign r_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[k];
            assign c_in   = r_c[k];
            assign d_in   = r_d[k];
            assign x_in   = r_x[k];
            assign rem_in = r_rem[k];
            assign r_in   = r_r[k];
        end
        always_comb begin
            t     = {rem_in[RW-1:0], x_in[M-1:M-2]};
            trial = {r_in, 2'b01};
            b     = (t >= trial);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
            if (i_en) begin
                r_c[k+1]   <= c_in;
                r_d[k+1]   <= d_in;
                r_x[k+1]   <= {x_in[M-3:0], 2'b00};
                r_rem[k+1] <= b ? (t - trial) : t;
                r_r[k+1]   <= {r_in[RW-2:0], b};
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_ctl   = r_c[RW];
    assign o_val   = r_d[RW];
    assign o_root  = r_r[RW];
endmodule
